[design/am_pm_fm_tone_modulator_core_assert.svh]
// Assertion macros for the tone modulator core.
`ifndef AM_PM_FM_TONE_MODULATOR_CORE_ASSERT_SVH
`define AM_PM_FM_TONE_MODULATOR_CORE_ASSERT_SVH

// Checks that the consequent holds in the cycle of the antecedent.
`define APFM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tone modulator assertion failed");

// Checks that the consequent holds from the cycle after the antecedent.
`define APFM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tone modulator assertion failed");

`endif

[design/apfm_pkg.sv]
// Package with the shared types, constants and sine table of the tone modulator.
package apfm_pkg;

   // Phase accumulator and sine table sizes.
   localparam int PHASE_BITS      = 32;
   localparam int SINE_TABLE_BITS = 10;
   localparam int QUARTER_LEN     = 1 << SINE_TABLE_BITS;
   localparam int ROM_ADDR_W      = SINE_TABLE_BITS + 1;

   // Field widths.
   localparam int STEP_W     = 32;
   localparam int DEPTH_W    = 16;
   localparam int DEV_W      = 24;
   localparam int SAMPLE_W   = 16;
   localparam int MAG_W      = 15;
   localparam int AM_W       = 24;
   localparam int ENV_W      = 25;
   localparam int MUL_A_W    = 25;
   localparam int PROD_W     = MUL_A_W + SAMPLE_W;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   // Fixed-point scaling.
   localparam int SAMPLE_FRAC    = 14;
   localparam int DEPTH_FRAC     = 8;
   localparam int ONE_Q14        = 1 << SAMPLE_FRAC;
   localparam int ENV_ROUND      = 1 << (DEPTH_FRAC - 1);
   localparam int AM_ROUND       = 1 << (SAMPLE_FRAC - 1);
   localparam int OFFSET_FRAC    = 34;
   localparam int SHIFT_UP       = (PHASE_BITS > OFFSET_FRAC) ? PHASE_BITS - OFFSET_FRAC : 0;
   localparam int SHIFT_DN       = (PHASE_BITS < OFFSET_FRAC) ? OFFSET_FRAC - PHASE_BITS : 0;
   localparam int OFS_ROUND      = (SHIFT_DN > 0) ? (1 << (SHIFT_DN - 1)) : 0;
   localparam int EXT_W          = PROD_W + SHIFT_UP + 1;

   // Register reset values.
   localparam logic [STEP_W-1:0]  CARRIER_STEP_RST = STEP_W'(214748365);
   localparam logic [STEP_W-1:0]  MESSAGE_STEP_RST = STEP_W'(53687091);
   localparam logic [DEPTH_W-1:0] AM_DEPTH_RST     = DEPTH_W'(128);
   localparam logic [DEV_W-1:0]   PM_DEV_RST       = DEV_W'(133504);
   localparam logic [DEV_W-1:0]   FM_DEV_RST       = DEV_W'(534);

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CARRIER_STEP = 3'd0,
      CSR_MESSAGE_STEP = 3'd1,
      CSR_AM_DEPTH     = 3'd2,
      CSR_PM_DEVIATION = 3'd3,
      CSR_FM_DEVIATION = 3'd4
   } csr_index_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MSG,
      ST_CAR,
      ST_PM,
      ST_AMP,
      ST_FM,
      ST_FIN
   } state_type;

   // Phase source of a table read.
   typedef enum logic [1:0] {
      ROM_MSG,
      ROM_CAR,
      ROM_MOD
   } rom_sel_type;

   // Operand pair of the shared multiplier.
   typedef enum logic [1:0] {
      MUL_PM,
      MUL_AM,
      MUL_FM,
      MUL_ENV
   } mul_sel_type;

   // Commands from the sequencer to the datapath.
   typedef struct packed {
      logic        accept;
      logic        rom_en;
      rom_sel_type rom_sel;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        m_load;
      logic        c_load;
      logic        pm_load;
      logic        env_load;
      logic        out_load;
   } cmd_type;

   // Address and sign of one quarter-wave table read.
   typedef struct packed {
      logic [ROM_ADDR_W-1:0] addr;
      logic                  negate;
   } rom_read_type;

   typedef logic [MAG_W-1:0] sine_table_type [0:QUARTER_LEN];

   // Unsigned quotient by shift and subtract; only evaluated while the table is built.
   function automatic longint unsigned div_unsigned(input longint unsigned num,
                                                    input longint unsigned den);
      longint unsigned quo;
      longint unsigned rem;
      quo = 0;
      rem = 0;
      for (int b = 63; b >= 0; b--) begin
         rem = (rem << 1) | {63'd0, num[b]};
         quo = quo << 1;
         if (rem >= den) begin
            rem = rem - den;
            quo = quo | 64'd1;
         end
      end
      return quo;
   endfunction

   // Quarter-wave sine table, evaluated by a fixed-point Taylor series at elaboration.
   function automatic sine_table_type build_sine_table();
      sine_table_type    tbl;
      longint unsigned   x;
      longint unsigned   x2;
      longint unsigned   term;
      longint unsigned   den;
      longint            sum;
      longint            r;
      for (int i = 0; i <= QUARTER_LEN; i++) begin
         x = (longint'(i) * 64'd1686629713 + longint'(QUARTER_LEN >> 1)) >> SINE_TABLE_BITS;
         x2 = (x * x) >> 30;
         term = x;
         sum = 0;
         for (int k = 0; k < 12; k++) begin
            if ((k & 1) == 1) begin
               sum = sum - longint'(term);
            end else begin
               sum = sum + longint'(term);
            end
            den = longint'((2 * k + 2) * (2 * k + 3));
            term = div_unsigned((term * x2) >> 30, den);
         end
         if (sum < 0) begin
            sum = 0;
         end
         r = (sum * 16384 + (longint'(1) <<< 29)) >>> 30;
         if (r > 16384) begin
            r = 16384;
         end
         tbl[i] = MAG_W'(r);
      end
      return tbl;
   endfunction

   localparam sine_table_type SINE_TABLE = build_sine_table();

   // Table address and sign for the sine, or the cosine, of a phase.
   function automatic rom_read_type sine_lookup(input logic [PHASE_BITS-1:0] phase,
                                                input logic cosine);
      logic [SINE_TABLE_BITS+1:0] top;
      logic [SINE_TABLE_BITS-1:0] idx;
      logic [1:0]                 quad;
      rom_read_type               rd;
      top = phase[PHASE_BITS-1 -: SINE_TABLE_BITS + 2];
      idx = top[SINE_TABLE_BITS-1:0];
      quad = top[SINE_TABLE_BITS+1:SINE_TABLE_BITS] + {1'b0, cosine};
      rd.addr = quad[0] ? ROM_ADDR_W'(QUARTER_LEN) - {1'b0, idx} : {1'b0, idx};
      rd.negate = quad[1];
      return rd;
   endfunction

endpackage

[design/apfm_ctrl.sv]
// Sequencer that steps one sample through the shared table and multiplier.
module apfm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output apfm_pkg::cmd_type cmd
);
   import apfm_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;
   logic      can_accept;

   // The output register is free when empty or being drained this cycle.
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign can_accept = (state_ff == ST_IDLE) || ((state_ff == ST_FIN) && out_free);
   assign req_stall  = !can_accept;
   assign rsp_valid  = rsp_valid_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_MSG;
         end
         ST_MSG: state_in = ST_CAR;
         ST_CAR: state_in = ST_PM;
         ST_PM:  state_in = ST_AMP;
         ST_AMP: state_in = ST_FM;
         ST_FM:  state_in = ST_FIN;
         ST_FIN: begin
            if (out_free) begin
               state_in = req_valid ? ST_MSG : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath commands for each step.
   always_comb begin
      cmd = '0;
      cmd.rom_sel = ROM_MSG;
      cmd.mul_sel = MUL_PM;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.accept = req_valid;
            cmd.rom_en = req_valid;
         end
         ST_MSG: begin
            cmd.m_load  = 1'b1;
            cmd.rom_en  = 1'b1;
            cmd.rom_sel = ROM_CAR;
         end
         ST_CAR: begin
            cmd.c_load  = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_PM;
         end
         ST_PM: begin
            cmd.rom_en  = 1'b1;
            cmd.rom_sel = ROM_MOD;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_AM;
         end
         ST_AMP: begin
            cmd.pm_load  = 1'b1;
            cmd.env_load = 1'b1;
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = MUL_FM;
         end
         ST_FM: begin
            cmd.rom_en  = 1'b1;
            cmd.rom_sel = ROM_MOD;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_ENV;
         end
         ST_FIN: begin
            cmd.out_load = out_free;
            cmd.accept   = out_free && req_valid;
            cmd.rom_en   = out_free && req_valid;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // Result valid flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[design/apfm_dpath.sv]
// Datapath with phase accumulators, sine table, shared multiplier and result registers.
module apfm_dpath (
   input  logic                                          clock,
   input  logic                                          reset,
   input  apfm_pkg::cmd_type                             cmd,
   input  logic                                          req_restart,
   input  logic                                          csr_write,
   input  logic [apfm_pkg::CSR_INDEX_W-1:0]              csr_index,
   input  logic [apfm_pkg::CSR_DATA_W-1:0]               csr_wdata,
   output logic signed [apfm_pkg::SAMPLE_W-1:0]          rsp_message_sample,
   output logic signed [apfm_pkg::AM_W-1:0]              rsp_am_sample,
   output logic signed [apfm_pkg::SAMPLE_W-1:0]          rsp_pm_sample,
   output logic signed [apfm_pkg::SAMPLE_W-1:0]          rsp_fm_sample
);
   import apfm_pkg::*;

   // Configuration registers.
   logic [STEP_W-1:0]  carrier_step_ff;
   logic [STEP_W-1:0]  message_step_ff;
   logic [DEPTH_W-1:0] am_depth_ff;
   logic [DEV_W-1:0]   pm_dev_ff;
   logic [DEV_W-1:0]   fm_dev_ff;

   // Phase state.
   logic [PHASE_BITS-1:0] carrier_phase_ff;
   logic [PHASE_BITS-1:0] message_phase_ff;
   logic [PHASE_BITS-1:0] car_cur_ff;
   logic [PHASE_BITS-1:0] car_start;
   logic [PHASE_BITS-1:0] msg_start;
   logic [PHASE_BITS-1:0] mod_phase;

   // Table read.
   rom_read_type       rom_rd;
   logic [MAG_W-1:0]   rom_data_ff;
   logic               rom_neg_ff;
   logic signed [SAMPLE_W-1:0] rom_mag;
   logic signed [SAMPLE_W-1:0] rom_sample;

   // Multiplier and working values.
   logic signed [MUL_A_W-1:0]  mul_a;
   logic signed [SAMPLE_W-1:0] mul_b;
   logic signed [PROD_W-1:0]   prod_in;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [SAMPLE_W-1:0] m_ff;
   logic signed [SAMPLE_W-1:0] c_ff;
   logic signed [SAMPLE_W-1:0] pm_ff;
   logic signed [ENV_W-1:0]    env_ff;
   logic signed [ENV_W-1:0]    env_in;
   logic signed [PROD_W-1:0]   env_round;
   logic signed [AM_W-1:0]     am_in;
   logic signed [EXT_W-1:0]    prod_ext;
   logic signed [EXT_W-1:0]    ofs_scaled;

   // Result registers.
   logic signed [SAMPLE_W-1:0] msg_out_ff;
   logic signed [AM_W-1:0]     am_out_ff;
   logic signed [SAMPLE_W-1:0] pm_out_ff;
   logic signed [SAMPLE_W-1:0] fm_out_ff;

   // Register writes; indexes past the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         carrier_step_ff <= CARRIER_STEP_RST;
         message_step_ff <= MESSAGE_STEP_RST;
         am_depth_ff     <= AM_DEPTH_RST;
         pm_dev_ff       <= PM_DEV_RST;
         fm_dev_ff       <= FM_DEV_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_CARRIER_STEP: carrier_step_ff <= csr_wdata[STEP_W-1:0];
            CSR_MESSAGE_STEP: message_step_ff <= csr_wdata[STEP_W-1:0];
            CSR_AM_DEPTH:     am_depth_ff     <= csr_wdata[DEPTH_W-1:0];
            CSR_PM_DEVIATION: pm_dev_ff       <= csr_wdata[DEV_W-1:0];
            CSR_FM_DEVIATION: fm_dev_ff       <= csr_wdata[DEV_W-1:0];
            default: ;
         endcase
      end
   end

   // Starting phases of this sample, zeroed on restart.
   assign car_start = req_restart ? '0 : carrier_phase_ff;
   assign msg_start = req_restart ? '0 : message_phase_ff;

   // Phase accumulators advance once per accepted transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         carrier_phase_ff <= '0;
         message_phase_ff <= '0;
      end else if (cmd.accept) begin
         carrier_phase_ff <= car_start + PHASE_BITS'(carrier_step_ff);
         message_phase_ff <= msg_start + PHASE_BITS'(message_step_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         car_cur_ff <= car_start;
      end
   end

   // Scale the deviation product from turns to phase units with rounding.
   assign prod_ext   = EXT_W'(prod_ff);
   assign ofs_scaled = ((prod_ext + EXT_W'(OFS_ROUND)) >>> SHIFT_DN) <<< SHIFT_UP;
   assign mod_phase  = car_cur_ff + ofs_scaled[PHASE_BITS-1:0];

   // Table address selection.
   always_comb begin
      case (cmd.rom_sel)
         ROM_MSG: rom_rd = sine_lookup(msg_start, 1'b0);
         ROM_CAR: rom_rd = sine_lookup(car_cur_ff, 1'b1);
         default: rom_rd = sine_lookup(mod_phase, 1'b1);
      endcase
   end

   // Registered table read.
   always_ff @(posedge clock) begin
      if (cmd.rom_en) begin
         rom_data_ff <= SINE_TABLE[rom_rd.addr];
         rom_neg_ff  <= rom_rd.negate;
      end
   end

   assign rom_mag    = $signed({1'b0, rom_data_ff});
   assign rom_sample = rom_neg_ff ? -rom_mag : rom_mag;

   // Shared multiplier operands.
   always_comb begin
      mul_b = m_ff;
      case (cmd.mul_sel)
         MUL_PM:  mul_a = $signed(MUL_A_W'(pm_dev_ff));
         MUL_AM:  mul_a = $signed(MUL_A_W'(am_depth_ff));
         MUL_FM:  mul_a = $signed(MUL_A_W'(fm_dev_ff));
         default: begin
            mul_a = env_ff;
            mul_b = c_ff;
         end
      endcase
   end

   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
   end

   // Envelope and AM sample, both rounded half up.
   assign env_round = (prod_ff + PROD_W'(ENV_ROUND)) >>> DEPTH_FRAC;
   assign env_in    = ENV_W'(env_round) + ENV_W'(ONE_Q14);
   assign am_in     = AM_W'((prod_ff + PROD_W'(AM_ROUND)) >>> SAMPLE_FRAC);

   // Working values captured along the sequence.
   always_ff @(posedge clock) begin
      if (cmd.m_load)   m_ff   <= rom_sample;
      if (cmd.c_load)   c_ff   <= rom_sample;
      if (cmd.pm_load)  pm_ff  <= rom_sample;
      if (cmd.env_load) env_ff <= env_in;
   end

   // Result registers, loaded when the output side has room.
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         msg_out_ff <= m_ff;
         am_out_ff  <= am_in;
         pm_out_ff  <= pm_ff;
         fm_out_ff  <= rom_sample;
      end
   end

   assign rsp_message_sample = msg_out_ff;
   assign rsp_am_sample      = am_out_ff;
   assign rsp_pm_sample      = pm_out_ff;
   assign rsp_fm_sample      = fm_out_ff;

endmodule

[design/am_pm_fm_tone_modulator_core.sv]
// The sequencer visits the one table read port and the one multiplier in turn, so a
// new transaction is not taken before the one in flight reaches its last step; there
// it is taken while the output register is empty or drains; else the step waits.
// Reset is synchronous and active high: both phases clear and the registers take their
// reset values; no clearing pass is needed.
module am_pm_fm_tone_modulator_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_restart,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [apfm_pkg::SAMPLE_W-1:0] rsp_message_sample,
   output logic signed [apfm_pkg::AM_W-1:0]     rsp_am_sample,
   output logic signed [apfm_pkg::SAMPLE_W-1:0] rsp_pm_sample,
   output logic signed [apfm_pkg::SAMPLE_W-1:0] rsp_fm_sample,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [apfm_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [apfm_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import apfm_pkg::*;

   cmd_type cmd;
   logic    csr_write;
   logic    req_fire;
   logic    samples_in_range;

   // Register writes are always taken.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign req_fire  = req_valid && !req_stall;

   apfm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   apfm_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_restart        (req_restart),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_message_sample (rsp_message_sample),
      .rsp_am_sample      (rsp_am_sample),
      .rsp_pm_sample      (rsp_pm_sample),
      .rsp_fm_sample      (rsp_fm_sample)
   );

   // The three table samples of the result all lie within the unit range.
   assign samples_in_range = (rsp_message_sample >= -16'sd16384) &&
                             (rsp_message_sample <= 16'sd16384) &&
                             (rsp_pm_sample >= -16'sd16384) &&
                             (rsp_pm_sample <= 16'sd16384) &&
                             (rsp_fm_sample >= -16'sd16384) &&
                             (rsp_fm_sample <= 16'sd16384);

`include "am_pm_fm_tone_modulator_core_assert.svh"

   // The sequencer is busy right after it takes a transaction.
   `APFM_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_fire, req_stall)

   // A taken transaction has its result waiting at the output after the finish step.
   `APFM_ASSERT_NEXT(a_result_latency, clock, reset, req_fire, ##6 rsp_valid)

   // Table samples never leave the unit range.
   `APFM_ASSERT_SAME(a_sample_range, clock, reset, rsp_valid, samples_in_range)

endmodule
